@@ rtl/core/crcp_pkg.sv @@
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared types and constants for the CRC-checked range frame parser.
// ----------------------------------------------------------------------------
package crcp_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int POS_W       = $clog2(FRAME_BYTES);

   localparam logic [POS_W-1:0] POS_ZERO  = '0;
   localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(1);
   localparam logic [POS_W-1:0] POS_FLAG  = POS_W'(2);
   localparam int               POS_DIST  = 3;
   localparam logic [POS_W-1:0] POS_TRAIL = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_MSB  = 16'h8000;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // result event codes
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_GOOD = 2'd1;
   localparam logic [1:0] EV_CRC  = 2'd2;
   localparam logic [1:0] EV_FMT  = 2'd3;

   // register indexes
   localparam int          CSR_IDX_W          = 2;
   localparam logic [1:0]  CSR_MARKER_FIRST   = 2'd0;
   localparam logic [1:0]  CSR_MARKER_SECOND  = 2'd1;
   localparam logic [1:0]  CSR_FLAG_FALSE     = 2'd2;
   localparam logic [1:0]  CSR_FLAG_TRUE      = 2'd3;

   localparam logic [7:0] RST_MARKER_FIRST  = 8'hAA;
   localparam logic [7:0] RST_MARKER_SECOND = 8'h55;
   localparam logic [7:0] RST_FLAG_FALSE    = 8'h00;
   localparam logic [7:0] RST_FLAG_TRUE     = 8'h01;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic        measure_valid;
      logic [31:0] distance_bits;
      logic [31:0] frame_time_ms;
      logic [31:0] good_frames;
      logic [31:0] crc_errors;
      logic [31:0] format_errors;
   } rsp_type;

   typedef struct packed {
      logic [7:0] marker_first;
      logic [7:0] marker_second;
      logic [7:0] flag_false;
      logic [7:0] flag_true;
   } cfg_type;

endpackage

@@ rtl/core/crc_checked_range_frame_parser.sv @@
// ----------------------------------------------------------------------------
// crc_checked_range_frame_parser
// Framed byte-stream parser with CRC-16/CCITT-FALSE check.
// Accepted item passes the input register, then the result register.
// Throughput: 1 item per cycle unless the result side stalls; the frame update
// is one pass through the core. One result item per input item. Result register
// frees the input side while a result waits. Reset (synchronous) clears the
// pipeline, frame state, latches, counters; loads default markers, flag codes.
// ----------------------------------------------------------------------------
module crc_checked_range_frame_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  crcp_pkg::req_type               req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output crcp_pkg::rsp_type               rsp_item,
   input  logic                            csr_we,
   input  logic [crcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_wdata
);
   import crcp_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;

   logic    out_free;
   logic    step;
   logic    accept;
   cfg_type cfg;
   rsp_type core_result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   crcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crcp_frame_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (step) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ rtl/core/crcp_csr.sv @@
// ----------------------------------------------------------------------------
// crcp_csr
// Configuration registers: start markers and flag codes.
// ----------------------------------------------------------------------------
module crcp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                         csr_wdata,
   output crcp_pkg::cfg_type                  cfg
);
   import crcp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MARKER_FIRST:  cfg_in.marker_first  = csr_wdata;
            CSR_MARKER_SECOND: cfg_in.marker_second = csr_wdata;
            CSR_FLAG_FALSE:    cfg_in.flag_false    = csr_wdata;
            CSR_FLAG_TRUE:     cfg_in.flag_true     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.marker_first  <= RST_MARKER_FIRST;
         cfg_ff.marker_second <= RST_MARKER_SECOND;
         cfg_ff.flag_false    <= RST_FLAG_FALSE;
         cfg_ff.flag_true     <= RST_FLAG_TRUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/crcp_crc16.sv @@
// ----------------------------------------------------------------------------
// crcp_crc16
// One-byte CRC-16 update, MSB first, poly 0x1021, no reflection.
// ----------------------------------------------------------------------------
module crcp_crc16 (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_nxt
);
   import crcp_pkg::*;

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_nxt = c;
   end

endmodule

@@ rtl/core/crcp_frame_core.sv @@
// ----------------------------------------------------------------------------
// crcp_frame_core
// Frame tracker: marker hunt, field capture, CRC check, latches and counters.
// Result is combinational from current state and the staged item.
// ----------------------------------------------------------------------------
module crcp_frame_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  crcp_pkg::req_type item,
   input  crcp_pkg::cfg_type cfg,
   output crcp_pkg::rsp_type result
);
   import crcp_pkg::*;

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [15:0]      crc_ff,   crc_in;
   logic [7:0]       flag_ff,  flag_in;
   logic [31:0]      dist_ff,  dist_in;
   logic [7:0]       trail_ff, trail_in;
   logic             last_valid_ff, last_valid_in;
   logic [31:0]      last_dist_ff,  last_dist_in;
   logic [31:0]      last_time_ff,  last_time_in;
   logic [31:0]      good_count_ff, good_count_in;
   logic [31:0]      crc_err_ff,    crc_err_in;
   logic [31:0]      fmt_err_ff,    fmt_err_in;

   logic        pos_idle;
   logic        is_first;
   logic        bad_second;
   logic [15:0] crc_src;
   logic [15:0] crc_new;
   logic [15:0] rx_crc;
   logic [1:0]  ev;

   // out-of-range position behaves as position zero
   assign pos_idle   = (pos_ff == POS_ZERO) ||
                       ({1'b0, pos_ff} >= (POS_W+1)'(FRAME_BYTES));
   assign is_first   = (item.rx_byte == cfg.marker_first);
   assign bad_second = !pos_idle && (pos_ff == POS_SYNC2) &&
                       (item.rx_byte != cfg.marker_second);
   assign crc_src    = (pos_idle || bad_second) ? CRC_INIT : crc_ff;
   assign rx_crc     = {item.rx_byte, trail_ff};

   crcp_crc16 u_crc (
      .crc_cur   (crc_src),
      .data_byte (item.rx_byte),
      .crc_nxt   (crc_new)
   );

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      flag_in       = flag_ff;
      dist_in       = dist_ff;
      trail_in      = trail_ff;
      last_valid_in = last_valid_ff;
      last_dist_in  = last_dist_ff;
      last_time_in  = last_time_ff;
      good_count_in = good_count_ff;
      crc_err_in    = crc_err_ff;
      fmt_err_in    = fmt_err_ff;
      ev            = EV_NONE;

      if (pos_idle) begin
         if (is_first) begin
            pos_in = POS_SYNC2;
            crc_in = crc_new;
         end else begin
            pos_in = POS_ZERO;
         end
      end else if (bad_second) begin
         fmt_err_in = fmt_err_ff + 32'd1;
         ev         = EV_FMT;
         if (is_first) begin
            pos_in = POS_SYNC2;
            crc_in = crc_new;
         end else begin
            pos_in = POS_ZERO;
            crc_in = CRC_INIT;
         end
      end else begin
         if (pos_ff == POS_FLAG) begin
            flag_in = item.rx_byte;
         end
         for (int k = 0; k < 4; k++) begin
            if (pos_ff == POS_W'(POS_DIST + k)) begin
               dist_in[8*k +: 8] = item.rx_byte;
            end
         end
         if (pos_ff == POS_TRAIL) begin
            trail_in = item.rx_byte;
         end
         if (pos_ff < POS_TRAIL) begin
            crc_in = crc_new;
         end
         pos_in = pos_ff + POS_W'(1);

         if (pos_ff == POS_LAST) begin
            pos_in = POS_ZERO;
            crc_in = CRC_INIT;
            if (crc_ff != rx_crc) begin
               crc_err_in = crc_err_ff + 32'd1;
               ev         = EV_CRC;
            end else if ((flag_ff != cfg.flag_false) && (flag_ff != cfg.flag_true)) begin
               fmt_err_in = fmt_err_ff + 32'd1;
               ev         = EV_FMT;
            end else begin
               last_valid_in = (flag_ff == cfg.flag_true);
               last_dist_in  = (flag_ff == cfg.flag_true) ? dist_ff : 32'd0;
               last_time_in  = item.time_ms;
               good_count_in = good_count_ff + 32'd1;
               ev            = EV_GOOD;
            end
         end
      end
   end

   always_comb begin
      result.event_res     = ev;
      result.measure_valid = last_valid_in;
      result.distance_bits = last_dist_in;
      result.frame_time_ms = last_time_in;
      result.good_frames   = good_count_in;
      result.crc_errors    = crc_err_in;
      result.format_errors = fmt_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_ZERO;
         crc_ff        <= CRC_INIT;
         last_valid_ff <= 1'b0;
         last_dist_ff  <= 32'd0;
         last_time_ff  <= 32'd0;
         good_count_ff <= 32'd0;
         crc_err_ff    <= 32'd0;
         fmt_err_ff    <= 32'd0;
      end else if (step) begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         last_valid_ff <= last_valid_in;
         last_dist_ff  <= last_dist_in;
         last_time_ff  <= last_time_in;
         good_count_ff <= good_count_in;
         crc_err_ff    <= crc_err_in;
         fmt_err_ff    <= fmt_err_in;
      end
   end

   // captured frame fields, no reset needed
   always_ff @(posedge clock) begin
      if (step) begin
         flag_ff  <= flag_in;
         dist_ff  <= dist_in;
         trail_ff <= trail_in;
      end
   end

   // CRC accumulator is back at its seed whenever the tracker is hunting
   a_crc_seed_when_idle: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_ZERO |-> crc_ff == CRC_INIT)
      else $error("crc not at seed while hunting");

   a_good_counts: assert property (@(posedge clock) disable iff (reset)
      step && result.event_res == EV_GOOD |=>
         good_count_ff == $past(good_count_ff) + 32'd1)
      else $error("good frame not counted");

   a_error_no_latch: assert property (@(posedge clock) disable iff (reset)
      step && (result.event_res == EV_CRC || result.event_res == EV_FMT) |=>
         last_time_ff == $past(last_time_ff) && last_dist_ff == $past(last_dist_ff))
      else $error("latched fields changed on an error");

   a_complete_rehunt: assert property (@(posedge clock) disable iff (reset)
      step && (result.event_res == EV_GOOD || result.event_res == EV_CRC) |=>
         pos_ff == POS_ZERO)
      else $error("no rehunt after frame completion");

endmodule

@@ verif/crc_checked_range_frame_parser_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_range_frame_parser_checker
// Watches the byte, result and register ports of the frame parser. It keeps
// its own copy of the frame state, CRC, latched measurement and counters, works
// out the result of every accepted byte and compares it, field by field, with
// the results in order of arrival.
// ----------------------------------------------------------------------------
module crc_checked_range_frame_parser_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  crcp_pkg::req_type               req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  crcp_pkg::rsp_type               rsp_item,
   input  logic                            csr_we,
   input  logic [crcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import crcp_pkg::*;

   cfg_type     regs;
   int unsigned pos;
   logic [7:0]  frame_q [FRAME_BYTES];
   logic [15:0] crc_run;
   logic        valid_l;
   logic [31:0] dist_l;
   logic [31:0] stamp_l;
   logic [31:0] n_good;
   logic [31:0] n_crc;
   logic [31:0] n_fmt;

   rsp_type     expected_rsp [$];
   int          n_fail;
   int          n_wait;

   assign fail_count = n_fail;
   assign pending    = n_wait;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   function automatic void start_frame(input logic [7:0] b);
      frame_q[0] = b;
      crc_run    = crc_step(CRC_INIT, b);
      pos        = 1;
   endfunction

   // advance the frame state by one byte; returns the result that byte causes
   function automatic rsp_type parse_byte(input logic [7:0] b, input logic [31:0] stamp);
      rsp_type     r;
      logic [1:0]  ev;
      logic [15:0] trailer;
      logic [7:0]  flag;
      ev = EV_NONE;
      if (pos >= FRAME_BYTES) pos = 0;
      if (pos == 0) begin
         if (b == regs.marker_first) start_frame(b);
      end else if (pos == 1 && b != regs.marker_second) begin
         n_fmt++;
         ev = EV_FMT;
         // a repeated first marker byte resyncs instead of hunting
         if (b == regs.marker_first) begin
            start_frame(b);
         end else begin
            pos = 0;
         end
      end else begin
         frame_q[pos] = b;
         if (pos < FRAME_BYTES - 2) crc_run = crc_step(crc_run, b);
         pos++;
         if (pos >= FRAME_BYTES) begin
            trailer = {frame_q[FRAME_BYTES-1], frame_q[FRAME_BYTES-2]};
            flag    = frame_q[2];
            pos     = 0;
            if (crc_run != trailer) begin
               n_crc++;
               ev = EV_CRC;
            end else if (flag != regs.flag_false && flag != regs.flag_true) begin
               n_fmt++;
               ev = EV_FMT;
            end else begin
               // flag_true wins when both codes are equal
               valid_l = (flag == regs.flag_true);
               dist_l  = valid_l ? {frame_q[POS_DIST+3], frame_q[POS_DIST+2],
                                    frame_q[POS_DIST+1], frame_q[POS_DIST]} : 32'h0;
               stamp_l = stamp;
               n_good++;
               ev = EV_GOOD;
            end
            crc_run = CRC_INIT;
         end
      end
      r.event_res     = ev;
      r.measure_valid = valid_l;
      r.distance_bits = dist_l;
      r.frame_time_ms = stamp_l;
      r.good_frames   = n_good;
      r.crc_errors    = n_crc;
      r.format_errors = n_fmt;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         n_fail++;
      end
   endfunction

   initial begin
      n_fail = 0;
      n_wait = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         regs.marker_first  = RST_MARKER_FIRST;
         regs.marker_second = RST_MARKER_SECOND;
         regs.flag_false    = RST_FLAG_FALSE;
         regs.flag_true     = RST_FLAG_TRUE;
         pos     = 0;
         crc_run = CRC_INIT;
         valid_l = 1'b0;
         dist_l  = '0;
         stamp_l = '0;
         n_good  = '0;
         n_crc   = '0;
         n_fmt   = '0;
         for (int i = 0; i < FRAME_BYTES; i++) frame_q[i] = 8'h00;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result item with nothing expected, expected none, got %h",
                        $time, rsp_item);
               n_fail++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("event_res",     32'(want.event_res),     32'(rsp_item.event_res));
               check_field("measure_valid", 32'(want.measure_valid),
                           32'(rsp_item.measure_valid));
               check_field("distance_bits", want.distance_bits, rsp_item.distance_bits);
               check_field("frame_time_ms", want.frame_time_ms, rsp_item.frame_time_ms);
               check_field("good_frames",   want.good_frames,   rsp_item.good_frames);
               check_field("crc_errors",    want.crc_errors,    rsp_item.crc_errors);
               check_field("format_errors", want.format_errors, rsp_item.format_errors);
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(parse_byte(req_item.rx_byte, req_item.time_ms));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MARKER_FIRST:  regs.marker_first  = csr_wdata;
               CSR_MARKER_SECOND: regs.marker_second = csr_wdata;
               CSR_FLAG_FALSE:    regs.flag_false    = csr_wdata;
               CSR_FLAG_TRUE:     regs.flag_true     = csr_wdata;
               default: ;
            endcase
         end
      end
      n_wait = expected_rsp.size();
   end

endmodule

@@ verif/tb_crc_checked_range_frame_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc_checked_range_frame_parser
// Byte-stream stimulus for the frame parser: a few hand-built frames, then
// random frames (good, corrupted, truncated, bad marker) mixed with noise,
// under several marker and flag settings. Sender bursts and receiver stalls
// are random; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_crc_checked_range_frame_parser;
   import crcp_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_item;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [7:0]            csr_wdata;

   int                    fail_count;
   int                    pending;

   cfg_type               cur_cfg;
   logic [7:0]            frame_buf [FRAME_BYTES];
   logic [31:0]           now_ms;
   int                    sent_count;
   int                    burst_left;
   bit                    hold_request;

   always #5 clock = ~clock;

   crc_checked_range_frame_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   crc_checked_range_frame_parser_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] next_stamp();
      if ($urandom_range(0, 4) == 0) return $urandom();
      now_ms += $urandom_range(0, 3);
      return now_ms;
   endfunction

   // well-formed frame for the current markers, trailer CRC filled in
   task automatic make_frame(input logic [7:0] flag, input logic [31:0] dist_bits);
      logic [15:0] crc;
      frame_buf[0] = cur_cfg.marker_first;
      frame_buf[1] = cur_cfg.marker_second;
      frame_buf[2] = flag;
      for (int i = 0; i < 4; i++) frame_buf[POS_DIST+i] = dist_bits[8*i +: 8];
      for (int i = POS_DIST + 4; i < FRAME_BYTES - 2; i++) frame_buf[i] = 8'($urandom());
      crc = CRC_INIT;
      for (int i = 0; i < FRAME_BYTES - 2; i++) crc = crc_next(crc, frame_buf[i]);
      frame_buf[FRAME_BYTES-2] = crc[7:0];
      frame_buf[FRAME_BYTES-1] = crc[15:8];
   endtask

   task automatic send_byte(input logic [7:0] b, input logic [31:0] stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= '{rx_byte: b, time_ms: stamp};
      do @(posedge clock); while (req_stall);
      burst_left--;
      sent_count++;
   endtask

   task automatic random_frame();
      logic [7:0]  flag;
      logic [31:0] dist_bits;
      int          damage;
      int          n;
      case ($urandom_range(0, 9)) inside
         [0:3]:   flag = cur_cfg.flag_true;
         [4:6]:   flag = cur_cfg.flag_false;
         default: flag = 8'($urandom());
      endcase
      case ($urandom_range(0, 9))
         0:       dist_bits = 32'h0;
         1:       dist_bits = 32'hFFFF_FFFF;
         default: dist_bits = $urandom();
      endcase
      make_frame(flag, dist_bits);
      n = FRAME_BYTES;
      damage = $urandom_range(0, 99);
      if (damage < 12) begin
         frame_buf[$urandom_range(2, FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (damage < 18) begin
         frame_buf[1] = $urandom_range(0, 1) ? cur_cfg.marker_first : 8'($urandom());
      end else if (damage < 22) begin
         n = $urandom_range(1, FRAME_BYTES - 1);
      end
      for (int i = 0; i < n; i++) send_byte(frame_buf[i], next_stamp());
   endtask

   task automatic random_traffic(input int count);
      int goal;
      goal = sent_count + count;
      while (sent_count < goal) begin
         if ($urandom_range(0, 9) < 7) begin
            random_frame();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_byte($urandom_range(0, 3) == 0 ? cur_cfg.marker_first : 8'($urandom()),
                         next_stamp());
            end
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // registers change only once every result is back and the pipe is empty
   task automatic set_regs(input cfg_type c);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_MARKER_FIRST,  c.marker_first);
      write_reg(CSR_MARKER_SECOND, c.marker_second);
      write_reg(CSR_FLAG_FALSE,    c.flag_false);
      write_reg(CSR_FLAG_TRUE,     c.flag_true);
      @(negedge clock);
      csr_we  <= 1'b0;
      cur_cfg = c;
   endtask

   // receiver: stall pattern changes mode now and then, plus long hold-offs
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      bit  hold_done;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
         end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
            hold_left = $urandom_range(50, 150);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_item     <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_MARKER_FIRST;
      csr_wdata    <= 8'h00;
      hold_request <= 1'b0;
      now_ms       = 32'h0;
      sent_count   = 0;
      burst_left   = 0;
      cur_cfg      = '{marker_first: RST_MARKER_FIRST, marker_second: RST_MARKER_SECOND,
                       flag_false: RST_FLAG_FALSE, flag_true: RST_FLAG_TRUE};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // noise while hunting, bad second byte, resync on a repeated first marker
      send_byte(8'h00, 32'h0);
      send_byte(8'hFF, 32'hFFFF_FFFF);
      send_byte(cur_cfg.marker_first, next_stamp());
      send_byte(8'h12, next_stamp());
      send_byte(cur_cfg.marker_first, next_stamp());
      make_frame(cur_cfg.flag_true, 32'hFFFF_FFFF);
      for (int i = 0; i < FRAME_BYTES; i++) begin
         send_byte(frame_buf[i], (i == FRAME_BYTES - 1) ? 32'hFFFF_FFFF : next_stamp());
      end
      // invalid-measurement frame with a broken trailer
      make_frame(cur_cfg.flag_false, 32'h0);
      frame_buf[FRAME_BYTES-1] ^= 8'h01;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         send_byte(frame_buf[i], (i == FRAME_BYTES - 1) ? 32'h0 : next_stamp());
      end
      random_traffic(350);

      set_regs('{marker_first: 8'h00, marker_second: 8'hFF,
                 flag_false: 8'hFF, flag_true: 8'h00});
      hold_request <= 1'b1;
      random_traffic(350);

      // equal markers and equal flag codes
      set_regs('{marker_first: 8'h7E, marker_second: 8'h7E,
                 flag_false: 8'h5A, flag_true: 8'h5A});
      random_traffic(350);

      set_regs('{marker_first: 8'($urandom()), marker_second: 8'($urandom()),
                 flag_false: 8'($urandom()), flag_true: 8'($urandom())});
      random_traffic(350);

      set_regs('{marker_first: RST_MARKER_FIRST, marker_second: RST_MARKER_SECOND,
                 flag_false: RST_FLAG_FALSE, flag_true: RST_FLAG_TRUE});
      random_traffic(350);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/crcp_pkg.sv
rtl/core/crcp_csr.sv
rtl/core/crcp_crc16.sv
rtl/core/crcp_frame_core.sv
rtl/core/crc_checked_range_frame_parser.sv
verif/crc_checked_range_frame_parser_checker.sv
verif/tb_crc_checked_range_frame_parser.sv
